[rtl/sbpf_pkg.sv]
// shared types and constants for the servo bus packet framer
package sbpf_pkg;

  // sync byte opening every packet
  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // default upper bound on parameter bytes per packet
  localparam int MAX_PARAMS_DEF = 58;

  // byte slots of one request's output sequence
  typedef enum logic [2:0] {
    POS_SYNC1,
    POS_SYNC2,
    POS_ID,
    POS_LEN,
    POS_INSTR,
    POS_PARAM,
    POS_CHK
  } sbpf_pos_t;

  // everything the serialiser needs to send the bytes of one request
  typedef struct packed {
    logic       hdr;        // header bytes go first
    logic       has_param;  // a parameter byte is sent
    logic       close;      // checksum closes the packet
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] instr;
    logic [7:0] pbyte;
    logic [7:0] chk;
  } sbpf_desc_t;

endpackage

[rtl/sbpf_frame.sv]
// request register stage: packet state and per-request byte plan
module sbpf_frame #(
  parameter int MaxParams = sbpf_pkg::MAX_PARAMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           servo_id,
  input  logic [7:0]           instr_code,
  input  logic [5:0]           param_count,
  input  logic [7:0]           param_byte,
  output logic                 desc_valid,
  input  logic                 desc_stall,
  output sbpf_pkg::sbpf_desc_t desc
);
  import sbpf_pkg::*;

  logic       in_packet;
  logic [5:0] bytes_left;
  logic [7:0] running_sum;

  logic       in_packet_next;
  logic [5:0] bytes_left_next;
  logic [7:0] running_sum_next;
  sbpf_desc_t desc_next;

  logic       accept;
  logic [5:0] count_sat;
  logic [7:0] len;
  logic [7:0] head_sum;
  logic [7:0] base_sum;
  logic [5:0] base_left;
  logic [7:0] sum_param;
  logic [5:0] left_after;

  // take a request whenever the plan register is free or being emptied
  assign in_stall = desc_valid && desc_stall;
  assign accept   = in_valid && !in_stall;

  // plan for this request and the packet state it leaves
  always_comb begin
    if ({2'b00, param_count} > 8'(MaxParams)) begin
      count_sat = 6'(MaxParams);
    end else begin
      count_sat = param_count;
    end
    len      = {2'b00, count_sat} + 8'd2;
    head_sum = servo_id + len + instr_code;

    base_sum  = in_packet ? running_sum : head_sum;
    base_left = in_packet ? bytes_left : count_sat;
    sum_param  = base_sum + param_byte;
    left_after = base_left - 6'd1;

    desc_next.hdr   = !in_packet;
    desc_next.id    = servo_id;
    desc_next.len   = len;
    desc_next.instr = instr_code;
    desc_next.pbyte = param_byte;

    if (!in_packet && count_sat == 6'd0) begin
      // empty packet: header and checksum only
      desc_next.has_param = 1'b0;
      desc_next.close     = 1'b1;
      desc_next.chk       = ~head_sum;
      in_packet_next      = 1'b0;
      bytes_left_next     = 6'd0;
      running_sum_next    = 8'd0;
    end else if (left_after == 6'd0) begin
      // final parameter closes the packet
      desc_next.has_param = 1'b1;
      desc_next.close     = 1'b1;
      desc_next.chk       = ~sum_param;
      in_packet_next      = 1'b0;
      bytes_left_next     = 6'd0;
      running_sum_next    = 8'd0;
    end else begin
      desc_next.has_param = 1'b1;
      desc_next.close     = 1'b0;
      desc_next.chk       = ~sum_param;
      in_packet_next      = 1'b1;
      bytes_left_next     = left_after;
      running_sum_next    = sum_param;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet   <= 1'b0;
      bytes_left  <= 6'd0;
      running_sum <= 8'd0;
      desc_valid  <= 1'b0;
    end else begin
      if (accept) begin
        in_packet   <= in_packet_next;
        bytes_left  <= bytes_left_next;
        running_sum <= running_sum_next;
        desc_valid  <= 1'b1;
      end else if (!desc_stall) begin
        desc_valid <= 1'b0;
      end
    end
  end

  // plan register
  always_ff @(posedge clk) begin
    if (accept) begin
      desc <= desc_next;
    end
  end

endmodule

[rtl/sbpf_serial.sv]
// byte serialiser: walks one request's plan onto the output channel
module sbpf_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 desc_valid,
  output logic                 desc_stall,
  input  sbpf_pkg::sbpf_desc_t desc,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           tx_byte,
  output logic                 last_of_item,
  output logic                 end_of_packet
);
  import sbpf_pkg::*;

  logic       busy;
  sbpf_pos_t  pos;
  sbpf_desc_t cur;

  logic       busy_next;
  sbpf_pos_t  pos_next;

  logic       sent;
  logic       take;
  sbpf_pos_t  start_pos;

  assign out_valid = busy;
  assign sent      = busy && !out_stall;
  assign desc_stall = busy && !(sent && last_of_item);
  assign take       = desc_valid && !desc_stall;
  assign start_pos  = desc.hdr ? POS_SYNC1 : POS_PARAM;

  // next byte slot
  always_comb begin
    busy_next = busy;
    pos_next  = pos;
    if (take) begin
      busy_next = 1'b1;
      pos_next  = start_pos;
    end else if (sent) begin
      case (pos)
        POS_SYNC1: pos_next = POS_SYNC2;
        POS_SYNC2: pos_next = POS_ID;
        POS_ID:    pos_next = POS_LEN;
        POS_LEN:   pos_next = POS_INSTR;
        POS_INSTR: pos_next = cur.has_param ? POS_PARAM : POS_CHK;
        POS_PARAM: begin
          if (cur.close) begin
            pos_next = POS_CHK;
          end else begin
            busy_next = 1'b0;
          end
        end
        POS_CHK:   busy_next = 1'b0;
        default:   busy_next = 1'b0;
      endcase
    end
  end

  // byte and flags for the current slot
  always_comb begin
    last_of_item  = 1'b0;
    end_of_packet = 1'b0;
    case (pos)
      POS_SYNC1: tx_byte = SYNC_BYTE;
      POS_SYNC2: tx_byte = SYNC_BYTE;
      POS_ID:    tx_byte = cur.id;
      POS_LEN:   tx_byte = cur.len;
      POS_INSTR: tx_byte = cur.instr;
      POS_PARAM: begin
        tx_byte      = cur.pbyte;
        last_of_item = !cur.close;
      end
      POS_CHK: begin
        tx_byte       = cur.chk;
        last_of_item  = 1'b1;
        end_of_packet = 1'b1;
      end
      default:   tx_byte = SYNC_BYTE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_SYNC1;
    end else begin
      busy <= busy_next;
      pos  <= pos_next;
    end
  end

  // current plan
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= desc;
    end
  end

endmodule

[rtl/servo_bus_packet_framer_top.sv]
// top level of the servo bus instruction packet framer
// Each request other than a zero-count one carries one parameter byte; the first
// request of a packet also carries id, instruction and parameter count (saturated
// to MaxParams) and sends FF FF id length instruction ahead of its parameter. The
// checksum follows the last parameter, and a zero-count request sends a whole
// six-byte packet. A request is registered into a byte plan, then a serialiser
// sends one byte per cycle while out_stall is low, so a request causes one to
// seven bytes on the output; the next request is taken into the plan register
// while the current one is still being sent.
module servo_bus_packet_framer_top #(
  parameter int MaxParams = sbpf_pkg::MAX_PARAMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] servo_id,
  input  logic [7:0] instr_code,
  input  logic [5:0] param_count,
  input  logic [7:0] param_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last_of_item,
  output logic       end_of_packet
);
  import sbpf_pkg::*;

  logic       desc_valid;
  logic       desc_stall;
  sbpf_desc_t desc;

  // request stage
  sbpf_frame #(
    .MaxParams (MaxParams)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .servo_id    (servo_id),
    .instr_code  (instr_code),
    .param_count (param_count),
    .param_byte  (param_byte),
    .desc_valid  (desc_valid),
    .desc_stall  (desc_stall),
    .desc        (desc)
  );

  // byte output
  sbpf_serial u_serial (
    .clk           (clk),
    .rst           (rst),
    .desc_valid    (desc_valid),
    .desc_stall    (desc_stall),
    .desc          (desc),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_byte       (tx_byte),
    .last_of_item  (last_of_item),
    .end_of_packet (end_of_packet)
  );

endmodule
